// ----- sv/nonce_replay_cache_core_defines.svh -----
// Assertion macros used by the nonce replay cache top level.
`ifndef NONCE_REPLAY_CACHE_CORE_DEFINES_SVH
`define NONCE_REPLAY_CACHE_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define NRC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define NRC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/nrc_pkg.sv -----
// Types, constants and codes of the nonce replay cache.
package nrc_pkg;

    localparam int TABLE_DEPTH_DEF = 64;
    localparam int KEY_BITS_DEF    = 64;
    localparam int TIME_BITS_DEF   = 32;

    localparam int KEY_FIELD_W  = 64;
    localparam int TIME_FIELD_W = 32;
    localparam int TIME_MAX_W   = 64;
    localparam int TTL_W        = 16;
    localparam int LIMIT_W      = 7;
    localparam int COUNT_W      = 7;
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 16;

    localparam logic [TTL_W-1:0]   TTL_RESET   = 16'd300;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;

    localparam logic [CFG_IDX_W-1:0] CFG_TTL   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT = 1'b1;

    localparam logic REQ_CHECK = 1'b0;
    localparam logic REQ_PURGE = 1'b1;

    typedef struct packed {
        logic                    req_type;
        logic [KEY_FIELD_W-1:0]  nonce_key;
        logic [TIME_FIELD_W-1:0] now_seconds;
    } nrc_req_t;

    typedef struct packed {
        logic               accepted;
        logic               table_full;
        logic [COUNT_W-1:0] entry_count;
    } nrc_rsp_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_WRITE,
        ST_FINISH
    } nrc_state_t;

    typedef enum logic [1:0] {
        SCAN_PURGE,
        SCAN_LOOKUP,
        SCAN_EVICT
    } nrc_scan_t;

    typedef struct packed {
        logic over_age;
        logic key_match;
    } nrc_eval_t;

endpackage

// ----- sv/nrc_slot_mem.sv -----
// Slot table memory: one write port, one registered read port.
module nrc_slot_mem #(
    parameter int DEPTH = nrc_pkg::TABLE_DEPTH_DEF,
    parameter int WIDTH = 1 + nrc_pkg::KEY_BITS_DEF + nrc_pkg::TIME_BITS_DEF
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- sv/nrc_entry_eval.sv -----
// Shared per-slot unit: age against a limit and key compare.
module nrc_entry_eval #(
    parameter int KEY_BITS  = nrc_pkg::KEY_BITS_DEF,
    parameter int TIME_BITS = nrc_pkg::TIME_BITS_DEF
) (
    input  logic [TIME_BITS-1:0]     slot_time,
    input  logic [TIME_BITS-1:0]     now,
    input  logic [nrc_pkg::TTL_W-1:0] max_age,
    input  logic [KEY_BITS-1:0]      slot_key,
    input  logic [KEY_BITS-1:0]      key,
    output nrc_pkg::nrc_eval_t       result
);

    logic [TIME_BITS-1:0] age;

    // a stored time ahead of now counts as age zero
    assign age = now - slot_time;
    assign result.over_age  = (now >= slot_time) && (age > TIME_BITS'(max_age));
    assign result.key_match = (slot_key == key);

endmodule

// ----- sv/nonce_replay_cache_core.sv -----
// Nonce replay cache top level: sequencer, occupancy and result register.
//
//  channel | dir | handshake            | payload
//  in      | in  | in_valid / in_ready   | in_data  (nrc_req_t)
//  out     | out | out_valid / out_ready | out_data (nrc_rsp_t)
//  cfg     | in  | cfg_we                | cfg_idx, cfg_wdata
//
// Each scan reads one slot per cycle through the single memory read port.
// A check scans, decides, may rescan once to evict at the limit, may write a slot and finishes;
// a purge scans, decides and finishes; a check with an empty key goes straight to finish.
// After reset a clearing pass over every slot holds in_ready low.
// in_ready is high only between requests; a held result stalls only the final step.
module nonce_replay_cache_core #(
    parameter int TABLE_DEPTH = nrc_pkg::TABLE_DEPTH_DEF,
    parameter int KEY_BITS    = nrc_pkg::KEY_BITS_DEF,
    parameter int TIME_BITS   = nrc_pkg::TIME_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  nrc_pkg::nrc_req_t                 in_data,
    output logic                              out_valid,
    input  logic                              out_ready,
    output nrc_pkg::nrc_rsp_t                 out_data,
    input  logic                              cfg_we,
    input  logic [nrc_pkg::CFG_IDX_W-1:0]     cfg_idx,
    input  logic [nrc_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

`include "nonce_replay_cache_core_defines.svh"

    localparam int AW      = $clog2(TABLE_DEPTH);
    localparam int OCC_W   = $clog2(TABLE_DEPTH + 1);
    localparam int CMP_W   = OCC_W + nrc_pkg::LIMIT_W;
    localparam int ENTRY_W = 1 + KEY_BITS + TIME_BITS;

    nrc_pkg::nrc_state_t state_reg, state_next;
    nrc_pkg::nrc_scan_t  scan_reg, scan_next;

    logic [OCC_W-1:0]   idx_reg, idx_next;
    logic               pend_reg, pend_next;
    logic [AW-1:0]      eval_idx_reg, eval_idx_next;
    logic [OCC_W-1:0]   occ_reg, occ_next;
    logic               drop_en_reg, drop_en_next;
    logic               hit_reg, hit_next;
    logic               live_reg, live_next;
    logic               free_reg, free_next;
    logic               res_acc_reg, res_acc_next;
    logic               res_full_reg, res_full_next;
    logic               out_valid_reg;

    logic [AW-1:0]      hit_idx_reg, hit_idx_next;
    logic [AW-1:0]      free_idx_reg, free_idx_next;
    logic [AW-1:0]      tgt_idx_reg, tgt_idx_next;
    logic [KEY_BITS-1:0]  key_reg, key_next;
    logic [TIME_BITS-1:0] now_reg, now_next;
    logic [nrc_pkg::TTL_W-1:0] max_age_reg, max_age_next;
    nrc_pkg::nrc_rsp_t  out_data_reg;

    logic [nrc_pkg::TTL_W-1:0]   ttl_reg;
    logic [nrc_pkg::LIMIT_W-1:0] limit_reg;

    logic                 in_xfer;
    logic                 in_purge;
    logic [KEY_BITS-1:0]  in_key;
    logic [nrc_pkg::TIME_MAX_W-1:0] in_now_wide;
    logic [TIME_BITS-1:0] in_now;

    logic [CMP_W-1:0] limit_ext, depth_ext, eff_limit, occ_ext;
    logic             at_limit, over_half;

    logic                 mem_we;
    logic [AW-1:0]        mem_wr_addr;
    logic [ENTRY_W-1:0]   mem_wr_data;
    logic [AW-1:0]        mem_rd_addr;
    logic [ENTRY_W-1:0]   mem_rd_data;
    logic                 rd_valid;
    logic [KEY_BITS-1:0]  rd_key;
    logic [TIME_BITS-1:0] rd_time;

    nrc_pkg::nrc_eval_t ev;
    logic drop, keep_valid, scan_done, out_load;
    logic dec_replay, dec_rescan, dec_refresh, dec_insert, dec_full;

    // request decode
    assign in_xfer     = in_valid && in_ready;
    assign in_purge    = (in_data.req_type == nrc_pkg::REQ_PURGE);
    assign in_key      = in_data.nonce_key[KEY_BITS-1:0];
    assign in_now_wide = nrc_pkg::TIME_MAX_W'(in_data.now_seconds);
    assign in_now      = in_now_wide[TIME_BITS-1:0];

    // effective limit is min(entry_limit, TABLE_DEPTH)
    assign limit_ext = CMP_W'(limit_reg);
    assign depth_ext = CMP_W'(TABLE_DEPTH);
    assign eff_limit = (limit_ext < depth_ext) ? limit_ext : depth_ext;
    assign occ_ext   = CMP_W'(occ_reg);
    assign at_limit  = (occ_ext >= eff_limit);
    assign over_half = (occ_ext > (eff_limit >> 1));

    assign rd_valid = mem_rd_data[ENTRY_W-1];
    assign rd_key   = mem_rd_data[TIME_BITS +: KEY_BITS];
    assign rd_time  = mem_rd_data[TIME_BITS-1:0];

    nrc_slot_mem #(
        .DEPTH (TABLE_DEPTH),
        .WIDTH (ENTRY_W)
    ) u_slot_mem (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    nrc_entry_eval #(
        .KEY_BITS  (KEY_BITS),
        .TIME_BITS (TIME_BITS)
    ) u_entry_eval (
        .slot_time (rd_time),
        .now       (now_reg),
        .max_age   (max_age_reg),
        .slot_key  (rd_key),
        .key       (key_reg),
        .result    (ev)
    );

    assign scan_done  = (idx_reg == OCC_W'(TABLE_DEPTH));
    assign drop       = pend_reg && rd_valid && drop_en_reg && ev.over_age;
    assign keep_valid = rd_valid && !drop;

    assign dec_replay  = (scan_reg == nrc_pkg::SCAN_LOOKUP) && hit_reg && live_reg;
    assign dec_rescan  = (scan_reg == nrc_pkg::SCAN_LOOKUP) && !dec_replay && at_limit;
    assign dec_refresh = (scan_reg != nrc_pkg::SCAN_PURGE) && !dec_replay && !dec_rescan
                         && hit_reg;
    assign dec_insert  = (scan_reg != nrc_pkg::SCAN_PURGE) && !dec_replay && !dec_rescan
                         && !hit_reg && !at_limit && free_reg;
    assign dec_full    = (scan_reg != nrc_pkg::SCAN_PURGE) && !dec_replay && !dec_rescan
                         && !dec_refresh && !dec_insert;

    assign out_load = (state_reg == nrc_pkg::ST_FINISH) && (!out_valid_reg || out_ready);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            nrc_pkg::ST_CLEAR:
            begin
                if (idx_reg == OCC_W'(TABLE_DEPTH - 1))
                begin
                    state_next = nrc_pkg::ST_IDLE;
                end
            end
            nrc_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (!in_purge && (in_key == '0))
                    begin
                        state_next = nrc_pkg::ST_FINISH;
                    end
                    else
                    begin
                        state_next = nrc_pkg::ST_SCAN;
                    end
                end
            end
            nrc_pkg::ST_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = nrc_pkg::ST_DECIDE;
                end
            end
            nrc_pkg::ST_DECIDE:
            begin
                if (dec_rescan)
                begin
                    state_next = nrc_pkg::ST_SCAN;
                end
                else if (dec_refresh || dec_insert)
                begin
                    state_next = nrc_pkg::ST_WRITE;
                end
                else
                begin
                    state_next = nrc_pkg::ST_FINISH;
                end
            end
            nrc_pkg::ST_WRITE:
            begin
                state_next = nrc_pkg::ST_FINISH;
            end
            nrc_pkg::ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = nrc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = nrc_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs of the sequencer: handshake and memory ports
    always_comb
    begin
        in_ready    = 1'b0;
        mem_we      = 1'b0;
        mem_wr_addr = eval_idx_reg;
        mem_wr_data = {1'b0, rd_key, rd_time};
        mem_rd_addr = idx_reg[AW-1:0];
        unique case (state_reg)
            nrc_pkg::ST_CLEAR:
            begin
                mem_we      = 1'b1;
                mem_wr_addr = idx_reg[AW-1:0];
                mem_wr_data = '0;
            end
            nrc_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            nrc_pkg::ST_SCAN:
            begin
                mem_we = drop;
            end
            nrc_pkg::ST_WRITE:
            begin
                mem_we      = 1'b1;
                mem_wr_addr = tgt_idx_reg;
                mem_wr_data = {1'b1, key_reg, now_reg};
            end
            nrc_pkg::ST_DECIDE, nrc_pkg::ST_FINISH:
            begin
                mem_we = 1'b0;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    // datapath next values
    always_comb
    begin
        idx_next      = idx_reg;
        pend_next     = 1'b0;
        eval_idx_next = idx_reg[AW-1:0];
        occ_next      = occ_reg;
        scan_next     = scan_reg;
        drop_en_next  = drop_en_reg;
        max_age_next  = max_age_reg;
        hit_next      = hit_reg;
        live_next     = live_reg;
        hit_idx_next  = hit_idx_reg;
        free_next     = free_reg;
        free_idx_next = free_idx_reg;
        tgt_idx_next  = tgt_idx_reg;
        key_next      = key_reg;
        now_next      = now_reg;
        res_acc_next  = res_acc_reg;
        res_full_next = res_full_reg;

        if (state_reg == nrc_pkg::ST_CLEAR)
        begin
            idx_next = idx_reg + 1'b1;
        end

        if (in_xfer)
        begin
            key_next      = in_key;
            now_next      = in_now;
            idx_next      = '0;
            hit_next      = 1'b0;
            free_next     = 1'b0;
            max_age_next  = ttl_reg;
            res_acc_next  = 1'b0;
            res_full_next = 1'b0;
            if (in_purge)
            begin
                scan_next    = nrc_pkg::SCAN_PURGE;
                drop_en_next = 1'b1;
            end
            else
            begin
                scan_next    = nrc_pkg::SCAN_LOOKUP;
                drop_en_next = over_half;
            end
        end

        if (state_reg == nrc_pkg::ST_SCAN)
        begin
            pend_next = !scan_done;
            if (!scan_done)
            begin
                idx_next = idx_reg + 1'b1;
            end
            if (drop)
            begin
                occ_next = occ_reg - 1'b1;
            end
            if (pend_reg && keep_valid && ev.key_match && !hit_reg)
            begin
                hit_next     = 1'b1;
                hit_idx_next = eval_idx_reg;
                live_next    = !ev.over_age;
            end
            if (pend_reg && !keep_valid && !free_reg)
            begin
                free_next     = 1'b1;
                free_idx_next = eval_idx_reg;
            end
        end

        if (state_reg == nrc_pkg::ST_DECIDE)
        begin
            if (dec_rescan)
            begin
                scan_next    = nrc_pkg::SCAN_EVICT;
                drop_en_next = 1'b1;
                max_age_next = ttl_reg >> 1;
                idx_next     = '0;
                hit_next     = 1'b0;
                free_next    = 1'b0;
            end
            if (dec_refresh)
            begin
                tgt_idx_next = hit_idx_reg;
                res_acc_next = 1'b1;
            end
            if (dec_insert)
            begin
                tgt_idx_next = free_idx_reg;
                res_acc_next = 1'b1;
                occ_next     = occ_reg + 1'b1;
            end
            res_full_next = dec_full;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= nrc_pkg::ST_CLEAR;
            scan_reg      <= nrc_pkg::SCAN_PURGE;
            idx_reg       <= '0;
            pend_reg      <= 1'b0;
            occ_reg       <= '0;
            drop_en_reg   <= 1'b0;
            hit_reg       <= 1'b0;
            live_reg      <= 1'b0;
            free_reg      <= 1'b0;
            res_acc_reg   <= 1'b0;
            res_full_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            ttl_reg       <= nrc_pkg::TTL_RESET;
            limit_reg     <= nrc_pkg::LIMIT_RESET;
        end
        else
        begin
            state_reg    <= state_next;
            scan_reg     <= scan_next;
            idx_reg      <= idx_next;
            pend_reg     <= pend_next;
            occ_reg      <= occ_next;
            drop_en_reg  <= drop_en_next;
            hit_reg      <= hit_next;
            live_reg     <= live_next;
            free_reg     <= free_next;
            res_acc_reg  <= res_acc_next;
            res_full_reg <= res_full_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_we && (cfg_idx == nrc_pkg::CFG_TTL))
            begin
                ttl_reg <= cfg_wdata;
            end
            if (cfg_we && (cfg_idx == nrc_pkg::CFG_LIMIT))
            begin
                limit_reg <= cfg_wdata[nrc_pkg::LIMIT_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        eval_idx_reg <= eval_idx_next;
        hit_idx_reg  <= hit_idx_next;
        free_idx_reg <= free_idx_next;
        tgt_idx_reg  <= tgt_idx_next;
        key_reg      <= key_next;
        now_reg      <= now_next;
        max_age_reg  <= max_age_next;
        if (out_load)
        begin
            out_data_reg.accepted    <= res_acc_reg;
            out_data_reg.table_full  <= res_full_reg;
            out_data_reg.entry_count <= occ_ext[nrc_pkg::COUNT_W-1:0];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    `NRC_ASSERT_NOW(a_occ_bound, 1'b1, occ_reg <= OCC_W'(TABLE_DEPTH), "occupancy above depth")
    `NRC_ASSERT_NOW(a_rsp_excl, out_valid_reg, !(out_data_reg.accepted && out_data_reg.table_full), "accepted and full together")
    `NRC_ASSERT_NOW(a_full_at_limit, (state_reg == nrc_pkg::ST_FINISH) && res_full_reg, at_limit, "full below limit")
    `NRC_ASSERT_NEXT(a_write_accepts, state_reg == nrc_pkg::ST_WRITE, (state_reg == nrc_pkg::ST_FINISH) && res_acc_reg, "slot write without accept")

endmodule

// ----- sim/nrc_replay_monitor.sv -----
// Watches the nonce cache channels, predicts each verdict and compares it with the DUT.
`timescale 1ns / 100ps
module nrc_replay_monitor (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    input  logic                             in_ready,
    input  nrc_pkg::nrc_req_t                in_data,
    input  logic                             out_valid,
    input  logic                             out_ready,
    input  nrc_pkg::nrc_rsp_t                out_data,
    input  logic                             cfg_we,
    input  logic [nrc_pkg::CFG_IDX_W-1:0]    cfg_idx,
    input  logic [nrc_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    output int                               fail_count,
    output int                               pending
);

    localparam int DEPTH = nrc_pkg::TABLE_DEPTH_DEF;
    localparam int REPORT_MAX = 10;
    localparam int KEY_W  = nrc_pkg::KEY_FIELD_W;
    localparam int TIME_W = nrc_pkg::TIME_FIELD_W;

    logic [KEY_W-1:0]            held_key   [DEPTH];
    logic [TIME_W-1:0]           held_time  [DEPTH];
    bit                          held_valid [DEPTH];
    int unsigned                 live_count;
    logic [nrc_pkg::TTL_W-1:0]   ttl;
    logic [nrc_pkg::LIMIT_W-1:0] limit;
    nrc_pkg::nrc_rsp_t           verdict_q [$];
    nrc_pkg::nrc_rsp_t           want;

    initial fail_count = 0;
    initial pending = 0;

    function automatic logic [TIME_W-1:0] age_at(int s, logic [TIME_W-1:0] now);
        return (now >= held_time[s]) ? now - held_time[s] : '0;
    endfunction

    function automatic void drop_stale(logic [TIME_W-1:0] now,
                                       logic [TIME_W-1:0] max_age);
        for (int s = 0; s < DEPTH; s++)
        begin
            if (held_valid[s] && age_at(s, now) > max_age)
            begin
                held_valid[s] = 1'b0;
                live_count--;
            end
        end
    endfunction

    function automatic int find_key(logic [KEY_W-1:0] key);
        for (int s = 0; s < DEPTH; s++)
        begin
            if (held_valid[s] && held_key[s] == key)
                return s;
        end
        return -1;
    endfunction

    // Applies one request to the shadow table and returns the verdict the DUT owes.
    function automatic nrc_pkg::nrc_rsp_t admit_nonce(nrc_pkg::nrc_req_t req);
        int unsigned       cap;
        int                hit;
        bit                placed;
        logic [TIME_W-1:0] now;
        logic [TIME_W-1:0] window;
        nrc_pkg::nrc_rsp_t rsp;
        cap    = (limit < DEPTH) ? limit : DEPTH;
        now    = req.now_seconds;
        window = {{(TIME_W-nrc_pkg::TTL_W){1'b0}}, ttl};
        placed = 1'b0;
        rsp    = '0;
        if (req.req_type == nrc_pkg::REQ_PURGE)
            drop_stale(now, window);
        else if (req.nonce_key != '0)
        begin
            if (live_count > cap / 2)
                drop_stale(now, window);
            hit = find_key(req.nonce_key);
            if (!(hit >= 0 && age_at(hit, now) <= window))
            begin
                if (live_count >= cap)
                begin
                    drop_stale(now, window >> 1);
                    hit = find_key(req.nonce_key);
                end
                if (hit >= 0)
                begin
                    held_time[hit] = now;
                    rsp.accepted = 1'b1;
                end
                else if (live_count >= cap)
                    rsp.table_full = 1'b1;
                else
                begin
                    for (int s = 0; s < DEPTH && !placed; s++)
                    begin
                        if (!held_valid[s])
                        begin
                            held_valid[s] = 1'b1;
                            held_key[s]   = req.nonce_key;
                            held_time[s]  = now;
                            live_count++;
                            placed = 1'b1;
                        end
                    end
                    rsp.accepted   = placed;
                    rsp.table_full = !placed;
                end
            end
        end
        rsp.entry_count = live_count[nrc_pkg::COUNT_W-1:0];
        return rsp;
    endfunction

    function automatic void note_failure(string msg);
        fail_count++;
        if (fail_count <= REPORT_MAX)
            $display("%0t: %s", $realtime, msg);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < DEPTH; s++)
                held_valid[s] = 1'b0;
            live_count = 0;
            ttl        = nrc_pkg::TTL_RESET;
            limit      = nrc_pkg::LIMIT_RESET;
            verdict_q.delete();
            pending    = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_idx == nrc_pkg::CFG_TTL)
                    ttl = cfg_wdata[nrc_pkg::TTL_W-1:0];
                else if (cfg_idx == nrc_pkg::CFG_LIMIT)
                    limit = cfg_wdata[nrc_pkg::LIMIT_W-1:0];
            end
            if (in_valid && in_ready)
                verdict_q.push_back(admit_nonce(in_data));
            if (out_valid && out_ready)
            begin
                if (verdict_q.size() == 0)
                    note_failure($sformatf("unexpected result transfer acc=%0d full=%0d cnt=%0d",
                                           out_data.accepted, out_data.table_full,
                                           out_data.entry_count));
                else
                begin
                    want = verdict_q.pop_front();
                    if (out_data.accepted !== want.accepted
                        || out_data.table_full !== want.table_full
                        || out_data.entry_count !== want.entry_count)
                        note_failure($sformatf(
                            "mismatch: exp acc=%0d full=%0d cnt=%0d, got acc=%0d full=%0d cnt=%0d",
                            want.accepted, want.table_full, want.entry_count,
                            out_data.accepted, out_data.table_full, out_data.entry_count));
                end
            end
            pending = verdict_q.size();
        end
    end

endmodule

// ----- sim/tb_nonce_replay_cache_core.sv -----
// Testbench top for the nonce replay cache: stimulus, flow control and verdict.
`timescale 1ns / 100ps
module tb_nonce_replay_cache_core;

    localparam int IDLE_PCT       = 21;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES    = 400;
    localparam int PHASES         = 12;
    localparam int PHASE_ITEMS    = 150;
    localparam int DRAIN_CYCLES   = 300;
    localparam int QUIET_PHASE    = 4;
    localparam int KEY_W          = nrc_pkg::KEY_FIELD_W;
    localparam int TIME_W         = nrc_pkg::TIME_FIELD_W;
    localparam int TTL_W          = nrc_pkg::TTL_W;
    localparam int LIM_W          = nrc_pkg::LIMIT_W;

    logic                           clk       = 1'b0;
    logic                           rst_n     = 1'b0;
    logic                           in_valid  = 1'b0;
    logic                           in_ready;
    nrc_pkg::nrc_req_t              in_data   = '0;
    logic                           out_valid;
    logic                           out_ready = 1'b0;
    nrc_pkg::nrc_rsp_t              out_data;
    logic                           cfg_we    = 1'b0;
    logic [nrc_pkg::CFG_IDX_W-1:0]  cfg_idx   = nrc_pkg::CFG_TTL;
    logic [nrc_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

    int fail_count;
    int pending;
    int sent_count = 0;
    int stall_count = 0;
    int hold_left = 0;
    int next_hold = 500;
    bit quiet = 1'b0;

    always #1 clk = ~clk;

    nonce_replay_cache_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_idx),
        .cfg_wdata (cfg_wdata)
    );

    nrc_replay_monitor monitor (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data),
        .cfg_we     (cfg_we),
        .cfg_idx    (cfg_idx),
        .cfg_wdata  (cfg_wdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            stall_count <= 0;
        else
            stall_count <= stall_count + 1;
        if (stall_count >= WATCHDOG_LIMIT)
        begin
            $display("tb_nonce_replay_cache_core NOT OK");
            $finish;
        end
    end

    // result side: random back-pressure plus long hold-offs to back up the input
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_left == 0 && sent_count >= next_hold)
            begin
                hold_left = HOLD_CYCLES;
                next_hold += 900;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    function automatic nrc_pkg::nrc_req_t mk_req(logic kind, logic [KEY_W-1:0] key,
                                                 logic [TIME_W-1:0] now);
        nrc_pkg::nrc_req_t req;
        req.req_type    = kind;
        req.nonce_key   = key;
        req.now_seconds = now;
        return req;
    endfunction

    task automatic send_req(input nrc_pkg::nrc_req_t req);
        while (!quiet && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sent_count++;
        @(negedge clk);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending != 0 || !in_ready)
            @(negedge clk);
    endtask

    task automatic write_regs(input logic [TTL_W-1:0] ttl, input logic [LIM_W-1:0] lim);
        cfg_we    <= 1'b1;
        cfg_idx   <= nrc_pkg::CFG_TTL;
        cfg_wdata <= ttl;
        @(negedge clk);
        cfg_idx   <= nrc_pkg::CFG_LIMIT;
        cfg_wdata <= {9'($urandom_range(511)), lim};
        @(negedge clk);
        cfg_we    <= 1'b0;
        @(negedge clk);
    endtask

    task automatic run_phase(input logic [TTL_W-1:0] ttl, input logic [LIM_W-1:0] lim,
                             input logic [TIME_W-1:0] base);
        logic [KEY_W-1:0]  pool [128];
        logic [TIME_W-1:0] now;
        int                pool_size;
        int                step_max;
        int                roll;
        nrc_pkg::nrc_req_t req;
        pool_size = 2 + $urandom_range((lim > 64 ? 64 : lim) * 3 / 2);
        case ($urandom_range(2))
            0:       step_max = ttl / 64 + 1;
            1:       step_max = ttl / 8 + 1;
            default: step_max = ttl / 2 + 1;
        endcase
        for (int k = 0; k < pool_size; k++)
        begin
            pool[k] = {$urandom, $urandom};
            if (pool[k] == '0)
                pool[k] = 64'd1;
        end
        now = base;
        repeat (PHASE_ITEMS)
        begin
            roll = $urandom_range(99);
            if (roll < 3)
                now = now - $urandom_range(step_max * 4);
            else if (roll < 8)
                now = now + ttl + $urandom_range(ttl + 8);
            else
                now = now + $urandom_range(step_max);
            roll = $urandom_range(99);
            req = mk_req(nrc_pkg::REQ_CHECK, pool[$urandom_range(pool_size - 1)], now);
            if (roll < 5)
            begin
                req.req_type  = nrc_pkg::REQ_PURGE;
                req.nonce_key = {$urandom, $urandom};
            end
            else if (roll < 8)
                req.nonce_key = '0;
            else if (roll < 18)
                req.nonce_key = {$urandom, $urandom};
            send_req(req);
        end
    endtask

    initial
    begin
        logic [TTL_W-1:0]  ttl_set [PHASES];
        logic [LIM_W-1:0]  lim_set [PHASES];
        logic [TIME_W-1:0] base;
        ttl_set = '{16'd0, 16'd65535, 16'd20, 16'd7, 16'd300, 16'd1,
                    16'd1000, 16'd3, 16'd65535, 16'd50, 16'd0, 16'd0};
        lim_set = '{7'd2, 7'd64, 7'd8, 7'd127, 7'd33, 7'd1,
                    7'd16, 7'd64, 7'd2, 7'd0, 7'd0, 7'd0};
        ttl_set[10] = $urandom_range(65535);
        ttl_set[11] = $urandom_range(200);
        lim_set[10] = $urandom_range(64, 2);
        lim_set[11] = $urandom_range(64, 2);

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        wait_idle();

        // reset register values: empty key, replay, backwards time, purge at max time
        send_req(mk_req(nrc_pkg::REQ_CHECK, 64'h0, 32'd0));
        send_req(mk_req(nrc_pkg::REQ_CHECK, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0));
        send_req(mk_req(nrc_pkg::REQ_CHECK, 64'hFFFF_FFFF_FFFF_FFFF, 32'd5));
        send_req(mk_req(nrc_pkg::REQ_CHECK, 64'd1, 32'd200));
        send_req(mk_req(nrc_pkg::REQ_CHECK, 64'd1, 32'd100));
        send_req(mk_req(nrc_pkg::REQ_PURGE, 64'h1234_5678_9ABC_DEF0, 32'hFFFF_FFFF));
        wait_idle();

        // short window, small limit: fill, full, cleanup, refresh in place, eviction
        write_regs(16'd10, 7'd4);
        send_req(mk_req(nrc_pkg::REQ_CHECK, 64'd2, 32'd1000));
        send_req(mk_req(nrc_pkg::REQ_CHECK, 64'd3, 32'd1001));
        send_req(mk_req(nrc_pkg::REQ_CHECK, 64'd4, 32'd1002));
        send_req(mk_req(nrc_pkg::REQ_CHECK, 64'd5, 32'd1003));
        send_req(mk_req(nrc_pkg::REQ_CHECK, 64'd6, 32'd1004));
        send_req(mk_req(nrc_pkg::REQ_CHECK, 64'd2, 32'd1020));
        send_req(mk_req(nrc_pkg::REQ_CHECK, 64'd7, 32'd1021));
        send_req(mk_req(nrc_pkg::REQ_CHECK, 64'd2, 32'd1040));
        send_req(mk_req(nrc_pkg::REQ_CHECK, 64'd8, 32'd1041));
        send_req(mk_req(nrc_pkg::REQ_CHECK, 64'd9, 32'd1046));
        send_req(mk_req(nrc_pkg::REQ_CHECK, 64'd10, 32'd1047));
        send_req(mk_req(nrc_pkg::REQ_CHECK, 64'd11, 32'd1048));
        send_req(mk_req(nrc_pkg::REQ_PURGE, 64'd0, 32'd1055));
        wait_idle();

        // limit of zero refuses everything, limit of one holds a single key
        write_regs(16'd10, 7'd0);
        send_req(mk_req(nrc_pkg::REQ_CHECK, 64'd12, 32'd1060));
        send_req(mk_req(nrc_pkg::REQ_CHECK, 64'd11, 32'd1061));
        wait_idle();
        write_regs(16'd10, 7'd1);
        send_req(mk_req(nrc_pkg::REQ_CHECK, 64'd13, 32'd1100));
        send_req(mk_req(nrc_pkg::REQ_CHECK, 64'd14, 32'd1101));
        send_req(mk_req(nrc_pkg::REQ_CHECK, 64'd14, 32'd1120));
        wait_idle();

        for (int p = 0; p < PHASES; p++)
        begin
            case (p % 3)
                0:       base = $urandom;
                1:       base = 32'hFFFF_FFFF - $urandom_range(200000);
                default: base = $urandom_range(1000);
            endcase
            write_regs(ttl_set[p], lim_set[p]);
            quiet = (p == QUIET_PHASE);
            run_phase(ttl_set[p], lim_set[p], base);
            wait_idle();
            quiet = 1'b0;
        end

        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("tb_nonce_replay_cache_core OK");
        else
            $display("tb_nonce_replay_cache_core NOT OK");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+sv
sv/nrc_pkg.sv
sv/nrc_slot_mem.sv
sv/nrc_entry_eval.sv
sv/nonce_replay_cache_core.sv
sim/nrc_replay_monitor.sv
sim/tb_nonce_replay_cache_core.sv
